// ===== rtl/scu_pkg.sv =====
// Shared definitions for the subtract/compare unit: status bit positions,
// opcodes and the item and result records passed between modules.
// No dependencies.
package scu_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned DataW   = 16;
  localparam int unsigned StatusW = 8;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned Digits  = DataW / NibbleW;

  // Status bit positions, N V M X D I Z C from the top down.
  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagM = 5;
  localparam int unsigned FlagX = 4;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [NibbleW-1:0] DecAdjust = 4'd10;

  typedef enum logic [OpcodeW-1:0] {
    OP_CMP_ACC = 3'd0,
    OP_CMP_IDX = 3'd1,
    OP_SBC     = 3'd2,
    OP_REP     = 3'd3,
    OP_SEP     = 3'd4
  } op_t;

  // One instruction as held in the input register.
  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [DataW-1:0]   operand;
    logic [DataW-1:0]   register_value;
    logic [StatusW-1:0] status;
  } item_t;

  // One answer as held in the result register.
  typedef struct packed {
    logic [DataW-1:0]   register_value;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

// ===== rtl/cpu_subtract_compare_unit.sv =====
// Top level of the subtract/compare unit: input register, datapath and
// result register with valid/ready handshakes on both sides.
// Depends on scu_pkg and scu_alu.
//
// The unit takes one instruction per clock while in_ready is high. Each
// instruction is held first in the input register and then in the result
// register, with the datapath between them. The input register loads
// whenever it is empty or the result register takes its item, so one new
// transfer is still taken while a finished result waits for the consumer;
// with both registers full and out_ready low, in_ready goes low. With
// out_ready held high the throughput is one item per cycle. Every
// instruction gives exactly one result.
module cpu_subtract_compare_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scu_pkg::OpcodeW-1:0] in_opcode,
  input  logic [scu_pkg::DataW-1:0]   in_operand,
  input  logic [scu_pkg::DataW-1:0]   in_register_value,
  input  logic [scu_pkg::StatusW-1:0] in_status_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scu_pkg::DataW-1:0]   out_register_out,
  output logic [scu_pkg::StatusW-1:0] out_status_out
);

  scu_pkg::item_t   item_r;
  scu_pkg::item_t   item_nxt;
  logic             item_valid_r;
  logic             item_valid_nxt;
  scu_pkg::result_t res_r;
  scu_pkg::result_t res_nxt;
  scu_pkg::result_t alu_res;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             res_load;
  logic             item_load;

  scu_alu u_alu (
    .item   (item_r),
    .result (alu_res)
  );

  // Stage enables: each register loads when it is empty or being drained.
  assign res_load  = ~out_valid_r | out_ready;
  assign item_load = ~item_valid_r | res_load;
  assign in_ready  = item_load;

  // Next values for the input register.
  always_comb begin
    item_nxt       = item_r;
    item_valid_nxt = item_valid_r;
    if (item_load) begin
      item_valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt.opcode         = in_opcode;
        item_nxt.operand        = in_operand;
        item_nxt.register_value = in_register_value;
        item_nxt.status         = in_status_in;
      end
    end
  end

  // Next values for the result register.
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = item_valid_r;
      if (item_valid_r) begin
        res_nxt = alu_res;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_register_out = res_r.register_value;
  assign out_status_out   = res_r.status;

endmodule

// ===== rtl/scu_alu.sv =====
// Combinational datapath of the subtract/compare unit: binary and
// packed-decimal subtraction, compares and status bit operations.
// Depends on scu_pkg.
module scu_alu (
  input  scu_pkg::item_t   item,
  output scu_pkg::result_t result
);

  always_comb begin
    logic                        narrow;
    logic                        borrow_in;
    logic [scu_pkg::DataW-1:0]   opa;
    logic [scu_pkg::DataW-1:0]   opb;
    logic [scu_pkg::DataW:0]     diff;
    logic [scu_pkg::DataW-1:0]   bin;
    logic [scu_pkg::Digits:0]    dec_borrow;
    logic [scu_pkg::DataW-1:0]   dec_full;
    logic [scu_pkg::DataW-1:0]   dec_res;
    logic [scu_pkg::NibbleW:0]   nib;
    logic [scu_pkg::DataW-1:0]   res;
    logic                        bout;
    logic                        neg;
    logic                        zero;
    logic                        ovf;
    logic [scu_pkg::StatusW-1:0] st;
    logic [scu_pkg::StatusW-1:0] mask;

    st   = item.status;
    mask = item.operand[scu_pkg::StatusW-1:0];

    // Width: the index compare follows X, everything else follows M.
    narrow = (item.opcode == scu_pkg::OP_CMP_IDX) ? st[scu_pkg::FlagX] : st[scu_pkg::FlagM];
    opa = narrow ? {8'h00, item.register_value[7:0]} : item.register_value;
    opb = narrow ? {8'h00, item.operand[7:0]} : item.operand;

    // Carry set means no borrow; compares subtract without a borrow in.
    borrow_in = (item.opcode == scu_pkg::OP_SBC) ? ~st[scu_pkg::FlagC] : 1'b0;

    // Binary subtraction; the top bit is the borrow out.
    diff = {1'b0, opa} - {1'b0, opb} - {{scu_pkg::DataW{1'b0}}, borrow_in};
    bin  = narrow ? {8'h00, diff[7:0]} : diff[scu_pkg::DataW-1:0];

    // Packed-decimal subtraction, one nibble at a time with ripple borrow.
    dec_borrow    = '0;
    dec_borrow[0] = borrow_in;
    dec_full      = '0;
    for (int k = 0; k < scu_pkg::Digits; k++) begin
      nib = {1'b0, opa[scu_pkg::NibbleW*k +: scu_pkg::NibbleW]}
          - {1'b0, opb[scu_pkg::NibbleW*k +: scu_pkg::NibbleW]}
          - {{scu_pkg::NibbleW{1'b0}}, dec_borrow[k]};
      if (nib[scu_pkg::NibbleW]) begin
        dec_full[scu_pkg::NibbleW*k +: scu_pkg::NibbleW] =
          nib[scu_pkg::NibbleW-1:0] + scu_pkg::DecAdjust;
        dec_borrow[k+1] = 1'b1;
      end else begin
        dec_full[scu_pkg::NibbleW*k +: scu_pkg::NibbleW] = nib[scu_pkg::NibbleW-1:0];
        dec_borrow[k+1] = 1'b0;
      end
    end
    dec_res = narrow ? {8'h00, dec_full[7:0]} : dec_full;

    // Decimal mode applies to subtraction only.
    if ((item.opcode == scu_pkg::OP_SBC) && st[scu_pkg::FlagD]) begin
      res  = dec_res;
      bout = narrow ? dec_borrow[2] : dec_borrow[scu_pkg::Digits];
    end else begin
      res  = bin;
      bout = diff[scu_pkg::DataW];
    end

    neg  = narrow ? res[7] : res[scu_pkg::DataW-1];
    zero = narrow ? (res[7:0] == 8'h00) : (res == '0);
    // Overflow always follows the binary signed rule.
    ovf  = narrow ? ((opa[7] ^ opb[7]) & (opa[7] ^ bin[7]))
                  : ((opa[scu_pkg::DataW-1] ^ opb[scu_pkg::DataW-1])
                     & (opa[scu_pkg::DataW-1] ^ bin[scu_pkg::DataW-1]));

    result.register_value = item.register_value;
    result.status         = st;

    unique case (item.opcode)
      scu_pkg::OP_CMP_ACC, scu_pkg::OP_CMP_IDX: begin
        result.status[scu_pkg::FlagN] = neg;
        result.status[scu_pkg::FlagZ] = zero;
        result.status[scu_pkg::FlagC] = ~bout;
      end
      scu_pkg::OP_SBC: begin
        result.status[scu_pkg::FlagN] = neg;
        result.status[scu_pkg::FlagZ] = zero;
        result.status[scu_pkg::FlagC] = ~bout;
        result.status[scu_pkg::FlagV] = ovf;
        // In 8-bit width the high byte of the register is kept.
        result.register_value = narrow ? {item.register_value[15:8], res[7:0]} : res;
      end
      scu_pkg::OP_REP: begin
        result.status = st & ~mask;
      end
      scu_pkg::OP_SEP: begin
        result.status = st | mask;
      end
      default: begin
        result.register_value = item.register_value;
        result.status         = st;
      end
    endcase
  end

endmodule

// ===== verif/tb_cpu_subtract_compare_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cpu_subtract_compare_unit: directed and random instructions
// are checked against a behavioural model of compare, subtract-with-borrow, REP and SEP.
// Depends on scu_pkg and the cpu_subtract_compare_unit RTL.
module tb_cpu_subtract_compare_unit;
  import scu_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned RandomItems   = 1330;
  localparam int unsigned DrainCycles   = 4;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OpcodeW-1:0] in_opcode;
  logic [DataW-1:0]   in_operand;
  logic [DataW-1:0]   in_register_value;
  logic [StatusW-1:0] in_status_in;
  logic               out_valid;
  logic               out_ready;
  logic [DataW-1:0]   out_register_out;
  logic [StatusW-1:0] out_status_out;

  // Results still owed by the unit, oldest first.
  result_t     awaited_alu_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          idling_on      = 1'b1;

  cpu_subtract_compare_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand        (in_operand),
    .in_register_value (in_register_value),
    .in_status_in      (in_status_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_register_out  (out_register_out),
    .out_status_out    (out_status_out)
  );

  always #HalfPeriod clk = ~clk;

  // Behavioural model of one instruction: new register value and new status byte.
  function automatic result_t compute_alu_result(input logic [OpcodeW-1:0] op,
                                                 input logic [DataW-1:0]   opnd,
                                                 input logic [DataW-1:0]   regv,
                                                 input logic [StatusW-1:0] st);
    result_t     res;
    logic        narrow;
    int unsigned mask, sign, a, m, borrow, diff, bin, value, digits, x, y, d, k;
    res.register_value = regv;
    res.status         = st;
    case (op)
      OP_CMP_ACC, OP_CMP_IDX: begin
        narrow = (op == OP_CMP_ACC) ? st[FlagM] : st[FlagX];
        mask   = narrow ? 'hFF : 'hFFFF;
        sign   = narrow ? 'h80 : 'h8000;
        a      = regv & mask;
        m      = opnd & mask;
        diff   = (a - m) & mask;
        res.status[FlagZ] = (diff == 0);
        res.status[FlagN] = ((diff & sign) != 0);
        res.status[FlagC] = (a >= m);
      end
      OP_SBC: begin
        narrow = st[FlagM];
        mask   = narrow ? 'hFF : 'hFFFF;
        sign   = narrow ? 'h80 : 'h8000;
        a      = regv & mask;
        m      = opnd & mask;
        borrow = st[FlagC] ? 0 : 1;
        bin    = (a - m - borrow) & mask;
        if (st[FlagD]) begin
          // Digit by digit, each nibble taking the borrow of the one below it.
          value  = 0;
          digits = narrow ? 2 : 4;
          for (k = 0; k < digits; k++) begin
            x = (a >> (4 * k)) & 'hF;
            y = (m >> (4 * k)) & 'hF;
            if (x >= y + borrow) begin
              d      = x - y - borrow;
              borrow = 0;
            end else begin
              d      = (x + 10 - y - borrow) & 'hF;
              borrow = 1;
            end
            value |= d << (4 * k);
          end
        end else begin
          value  = bin;
          borrow = (a >= m + borrow) ? 0 : 1;
        end
        res.status[FlagZ]  = ((value & mask) == 0);
        res.status[FlagN]  = ((value & sign) != 0);
        res.status[FlagC]  = (borrow == 0);
        // Overflow always follows the binary rule, even in decimal mode.
        res.status[FlagV]  = (((a ^ m) & (a ^ bin) & sign) != 0);
        res.register_value = DataW'((regv & ~mask) | value);
      end
      OP_REP: res.status = st & ~opnd[StatusW-1:0];
      OP_SEP: res.status = st | opnd[StatusW-1:0];
      default: ;
    endcase
    return res;
  endfunction

  // Random word with a bias towards the boundary values of both widths.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'h0080;
      5:       return 16'h007F;
      default: return DataW'($urandom);
    endcase
  endfunction

  // Random word made only of valid decimal digits.
  function automatic logic [DataW-1:0] pick_bcd();
    logic [DataW-1:0] w;
    for (int unsigned k = 0; k < Digits; k++) begin
      w[k*NibbleW +: NibbleW] = NibbleW'($urandom_range(0, 9));
    end
    return w;
  endfunction

  // Drive one instruction and record its result once the transfer has taken place.
  task automatic send_item(input op_t op, input logic [DataW-1:0] opnd,
                           input logic [DataW-1:0] regv, input logic [StatusW-1:0] st);
    @(negedge clk);
    while (idling_on && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_opcode         <= op;
    in_operand        <= opnd;
    in_register_value <= regv;
    in_status_in      <= st;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    awaited_alu_results.push_back(compute_alu_result(op, opnd, regv, st));
  endtask

  // Accumulator compare at both widths; the other flags must survive.
  task automatic test_compare_accumulator();
    send_item(OP_CMP_ACC, 16'h34FF, 16'h12FF, 8'h20);
    send_item(OP_CMP_ACC, 16'h00FF, 16'h0000, 8'h20);
    send_item(OP_CMP_ACC, 16'h0000, 16'hFFFF, 8'h00);
    send_item(OP_CMP_ACC, 16'hFFFF, 16'h0000, 8'hDF);
  endtask

  // Index compare follows X, not M.
  task automatic test_compare_index();
    send_item(OP_CMP_IDX, 16'h0001, 16'hAB80, 8'h10);
    send_item(OP_CMP_IDX, 16'h8000, 16'h8000, 8'h20);
    send_item(OP_CMP_IDX, 16'h8000, 16'h7FFF, 8'h00);
    send_item(OP_CMP_IDX, 16'h01FF, 16'h02FF, 8'hDF);
  endtask

  // Binary subtract: borrow in and out, signed overflow, kept high byte.
  task automatic test_subtract_binary();
    send_item(OP_SBC, 16'h0001, 16'h8000, 8'h01);
    send_item(OP_SBC, 16'h0000, 16'h0000, 8'h00);
    send_item(OP_SBC, 16'h00FF, 16'hAB7F, 8'h21);
    send_item(OP_SBC, 16'h0001, 16'h1280, 8'h20);
    send_item(OP_SBC, 16'hFFFF, 16'hFFFF, 8'hC1);
  endtask

  // Decimal subtract, including nibbles above nine.
  task automatic test_subtract_decimal();
    send_item(OP_SBC, 16'h0001, 16'h1000, 8'h09);
    send_item(OP_SBC, 16'h0000, 16'h0000, 8'h08);
    send_item(OP_SBC, 16'h0099, 16'h5599, 8'h29);
    send_item(OP_SBC, 16'h0049, 16'h0050, 8'h28);
    send_item(OP_SBC, 16'h0B0C, 16'hFAFA, 8'h09);
    send_item(OP_SBC, 16'h00FF, 16'h00AF, 8'h28);
  endtask

  // REP and SEP with full, empty and mixed masks; the high byte is ignored.
  task automatic test_status_ops();
    send_item(OP_REP, 16'h00FF, 16'h1234, 8'hFF);
    send_item(OP_REP, 16'hFF00, 16'hFFFF, 8'hA5);
    send_item(OP_SEP, 16'h00FF, 16'h0000, 8'h00);
    send_item(OP_SEP, 16'hFF5A, 16'h8001, 8'h81);
  endtask

  // Random mix of all operations, with a stretch where neither side idles.
  task automatic test_random_mix();
    op_t              op;
    logic [DataW-1:0] opnd, regv;
    logic [StatusW-1:0] st;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      idling_on = !(i >= 400 && i < 650);
      op   = op_t'($urandom_range(0, 4));
      st   = StatusW'($urandom);
      opnd = pick_word();
      regv = pick_word();
      if (op == OP_SBC && st[FlagD] && $urandom_range(0, 2) != 0) begin
        opnd = pick_bcd();
        regv = pick_bcd();
      end
      // Equal operands give zero differences for compares and for SBC with carry set.
      if ($urandom_range(0, 9) == 0) begin
        opnd = regv;
      end
      send_item(op, opnd, regv, st);
    end
    idling_on = 1'b1;
  endtask

  // The consumer stalls at random while idling is enabled.
  always @(negedge clk) begin
    out_ready <= !(idling_on && $urandom_range(0, 99) < 7);
  end

  // Compare each result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_alu_results.size() == 0) begin
        $display("%0t: unexpected result, register_out %h status_out %h",
                 $time, out_register_out, out_status_out);
        mismatch_count++;
      end else begin
        want = awaited_alu_results.pop_front();
        if (out_register_out !== want.register_value) begin
          $display("%0t: register_out mismatch, expected %h, actual %h",
                   $time, want.register_value, out_register_out);
          mismatch_count++;
        end
        if (out_status_out !== want.status) begin
          $display("%0t: status_out mismatch, expected %h, actual %h",
                   $time, want.status, out_status_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_CMP_ACC;
    in_operand        = '0;
    in_register_value = '0;
    in_status_in      = '0;
    out_ready         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_compare_accumulator();
    test_compare_index();
    test_subtract_binary();
    test_subtract_decimal();
    test_status_ops();
    test_random_mix();

    @(negedge clk) in_valid <= 1'b0;
    while (awaited_alu_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== cpu_subtract_compare_unit.f =====
rtl/scu_pkg.sv
rtl/scu_alu.sv
rtl/cpu_subtract_compare_unit.sv
verif/tb_cpu_subtract_compare_unit.sv
